// ===== hdl/hcp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcp_pkg
// Types, codes and byte classes shared by the cookie header parser.
// ----------------------------------------------------------------------------
package hcp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_PRE_NAME    = 4'd1,
    PH_NAME        = 4'd2,
    PH_AFTER_NAME  = 4'd3,
    PH_PRE_VALUE   = 4'd4,
    PH_BARE        = 4'd5,
    PH_QUOTED      = 4'd6,
    PH_AFTER_VALUE = 4'd7,
    PH_ERROR       = 4'd8
  } phase_t;

  localparam logic [1:0] ROLE_SKIP  = 2'd0;
  localparam logic [1:0] ROLE_NAME  = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;
  localparam logic [1:0] ROLE_DROP  = 2'd3;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_END_PRE_NAME  = 4'd1;
  localparam logic [3:0] ERR_BAD_PRE_NAME  = 4'd2;
  localparam logic [3:0] ERR_END_PRE_VALUE = 4'd3;
  localparam logic [3:0] ERR_NO_EQUALS     = 4'd4;
  localparam logic [3:0] ERR_END_QUOTED    = 4'd5;
  localparam logic [3:0] ERR_BAD_QUOTED    = 4'd6;
  localparam logic [3:0] ERR_NO_SEMICOLON  = 4'd7;
  localparam logic [3:0] ERR_OPEN_HEADER   = 4'd8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [15:0] IGNORED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic        cookie_end;
    logic        cookie_kept;
    logic [3:0]  cookie_slot;
    logic [3:0]  error_code;
    logic        report_valid;
    logic [4:0]  kept_total;
    logic [15:0] ignored_total;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return (b == 8'h28) || (b == 8'h29) || (b == 8'h3C) || (b == 8'h3E) ||
           (b == 8'h40) || (b == CH_COMMA) || (b == CH_SEMI) || (b == 8'h3A) ||
           (b == CH_BSLASH) || (b == CH_QUOTE) || (b == 8'h2F) || (b == 8'h3F) ||
           (b == 8'h5B) || (b == 8'h5D) || (b == 8'h7B) || (b == 8'h7D) ||
           (b == CH_EQUALS);
  endfunction

  function automatic logic is_ascii_text(input logic [7:0] b);
    return (b >= CH_SPACE) && !b[7];
  endfunction

  function automatic logic is_name_byte(input logic [7:0] b);
    return is_ascii_text(b) && !is_sep(b);
  endfunction

  function automatic logic is_value_byte(input logic [7:0] b);
    return is_ascii_text(b) && (b != CH_QUOTE) && (b != CH_SPACE) &&
           (b != CH_COMMA) && (b != CH_SEMI) && (b != CH_BSLASH);
  endfunction

endpackage

// ===== hdl/hcp_if.sv =====
// ----------------------------------------------------------------------------
// hcp_in_if / hcp_out_if
// Valid/ready channels for header bytes and per-byte parse results.
// ----------------------------------------------------------------------------
interface hcp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface hcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic        cookie_end;
  logic        cookie_kept;
  logic [3:0]  cookie_slot;
  logic [3:0]  error_code;
  logic        report_valid;
  logic [4:0]  kept_total;
  logic [15:0] ignored_total;

  modport source (
    output valid, output byte_role, output cookie_end, output cookie_kept,
    output cookie_slot, output error_code, output report_valid,
    output kept_total, output ignored_total, input ready
  );
  modport sink (
    input valid, input byte_role, input cookie_end, input cookie_kept,
    input cookie_slot, input error_code, input report_valid,
    input kept_total, input ignored_total, output ready
  );
endinterface

// ===== hdl/hcp_step.sv =====
// ----------------------------------------------------------------------------
// hcp_step
// Next-state and result logic for one header byte or finish item.
// ----------------------------------------------------------------------------
module hcp_step #(
  parameter int MAX_COOKIES = 16,
  parameter int KW          = 5
) (
  input  hcp_pkg::phase_t  phase,
  input  logic [KW-1:0]    kept,
  input  logic [15:0]      ignored,
  input  logic [3:0]       err,
  input  logic             mode,
  input  logic [7:0]       data_byte,
  output hcp_pkg::phase_t  phase_next,
  output logic [KW-1:0]    kept_next,
  output logic [15:0]      ignored_next,
  output logic [3:0]       err_next,
  output hcp_pkg::result_t res
);
  import hcp_pkg::*;

  logic          do_complete;
  logic          do_after;
  logic [KW+4:0] kept_ext;
  logic [KW+4:0] kept_next_ext;
  logic [3:0]    final_err;

  assign kept_ext      = {5'd0, kept};
  assign kept_next_ext = {5'd0, kept_next};

  always_comb begin
    phase_next   = phase;
    kept_next    = kept;
    ignored_next = ignored;
    err_next     = err;
    do_complete  = 1'b0;
    do_after     = 1'b0;
    res          = '0;
    final_err    = err;

    unique case (phase)
      PH_IDLE, PH_PRE_NAME: begin
        if (is_space(data_byte)) begin
          phase_next = PH_PRE_NAME;
        end else if (is_name_byte(data_byte)) begin
          res.byte_role = ROLE_NAME;
          phase_next    = PH_NAME;
        end else begin
          err_next      = (data_byte == CH_NUL) ? ERR_END_PRE_NAME : ERR_BAD_PRE_NAME;
          phase_next    = PH_ERROR;
          res.byte_role = ROLE_DROP;
        end
      end
      PH_NAME, PH_AFTER_NAME: begin
        if (phase == PH_NAME && is_name_byte(data_byte)) begin
          res.byte_role = ROLE_NAME;
        end else if (is_space(data_byte)) begin
          phase_next = PH_AFTER_NAME;
        end else if (data_byte == CH_EQUALS) begin
          phase_next = PH_PRE_VALUE;
        end else begin
          err_next      = (data_byte == CH_NUL) ? ERR_END_PRE_VALUE : ERR_NO_EQUALS;
          phase_next    = PH_ERROR;
          res.byte_role = ROLE_DROP;
        end
      end
      PH_PRE_VALUE: begin
        if (is_space(data_byte)) begin
          phase_next = PH_PRE_VALUE;
        end else if (data_byte == CH_QUOTE) begin
          phase_next = PH_QUOTED;
        end else if (is_value_byte(data_byte)) begin
          res.byte_role = ROLE_VALUE;
          phase_next    = PH_BARE;
        end else begin
          do_complete = 1'b1;
          do_after    = 1'b1;
        end
      end
      PH_BARE: begin
        if (is_value_byte(data_byte)) begin
          res.byte_role = ROLE_VALUE;
        end else begin
          do_complete = 1'b1;
          do_after    = 1'b1;
        end
      end
      PH_QUOTED: begin
        if (is_value_byte(data_byte)) begin
          res.byte_role = ROLE_VALUE;
        end else if (data_byte == CH_QUOTE) begin
          do_complete = 1'b1;
          phase_next  = PH_AFTER_VALUE;
        end else begin
          err_next      = (data_byte == CH_NUL) ? ERR_END_QUOTED : ERR_BAD_QUOTED;
          phase_next    = PH_ERROR;
          res.byte_role = ROLE_DROP;
        end
      end
      PH_AFTER_VALUE: begin
        do_after = 1'b1;
      end
      default: begin
        res.byte_role = ROLE_DROP;
        phase_next    = PH_ERROR;
      end
    endcase

    if (do_complete) begin
      res.cookie_end = 1'b1;
      if (kept < KW'(MAX_COOKIES)) begin
        res.cookie_kept = 1'b1;
        res.cookie_slot = kept_ext[3:0];
        kept_next       = kept + KW'(1);
      end else if (ignored != IGNORED_MAX) begin
        ignored_next = ignored + 16'd1;
      end
    end

    if (do_after) begin
      res.byte_role = ROLE_SKIP;
      if (is_space(data_byte)) begin
        phase_next = PH_AFTER_VALUE;
      end else if (data_byte == CH_NUL) begin
        phase_next = PH_IDLE;
      end else if (data_byte == CH_SEMI) begin
        phase_next = PH_PRE_NAME;
      end else begin
        err_next      = ERR_NO_SEMICOLON;
        phase_next    = PH_ERROR;
        res.byte_role = ROLE_DROP;
      end
    end

    res.error_code    = err_next;
    res.kept_total    = kept_next_ext[4:0];
    res.ignored_total = ignored_next;

    // finish: report totals and return to the reset state
    if (mode) begin
      if (err == ERR_NONE && phase != PH_IDLE) begin
        final_err = ERR_OPEN_HEADER;
      end
      res               = '0;
      res.error_code    = final_err;
      res.report_valid  = 1'b1;
      res.kept_total    = kept_ext[4:0];
      res.ignored_total = ignored;
      phase_next        = PH_IDLE;
      kept_next         = '0;
      ignored_next      = '0;
      err_next          = ERR_NONE;
    end
  end

endmodule

// ===== hdl/http_cookie_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// http_cookie_header_parser_top
// Cookie header byte parser: input register, one step of parse logic,
// result register.
// ----------------------------------------------------------------------------
// an item is held in the input register, then its result in the result register
// throughput: one item per cycle while results are taken, set by the combinational parse step
// a stalled result holds the step; the input register still takes one item
// reset: parse phase idle, cookie counts and latched error cleared,
// both pipeline registers empty
// ----------------------------------------------------------------------------
module http_cookie_header_parser_top #(
  parameter int MAX_COOKIES = 16
) (
  input logic      clk,
  input logic      rst,
  hcp_in_if.sink   req,
  hcp_out_if.source rsp
);
  import hcp_pkg::*;

  localparam int KW = $clog2(MAX_COOKIES + 1);

  logic          in_vld;
  logic          in_mode;
  logic [7:0]    in_byte;
  logic          out_vld;
  result_t       out_data;

  phase_t        phase;
  logic [KW-1:0] kept;
  logic [15:0]   ignored;
  logic [3:0]    err;

  phase_t        phase_next;
  logic [KW-1:0] kept_next;
  logic [15:0]   ignored_next;
  logic [3:0]    err_next;
  result_t       res;

  logic          advance;

  assign advance   = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || advance;

  hcp_step #(
    .MAX_COOKIES (MAX_COOKIES),
    .KW          (KW)
  ) u_step (
    .phase        (phase),
    .kept         (kept),
    .ignored      (ignored),
    .err          (err),
    .mode         (in_mode),
    .data_byte    (in_byte),
    .phase_next   (phase_next),
    .kept_next    (kept_next),
    .ignored_next (ignored_next),
    .err_next     (err_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_mode <= req.mode;
      in_byte <= req.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      kept    <= '0;
      ignored <= '0;
      err     <= ERR_NONE;
      out_vld <= 1'b0;
    end else if (advance) begin
      phase   <= phase_next;
      kept    <= kept_next;
      ignored <= ignored_next;
      err     <= err_next;
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.byte_role     = out_data.byte_role;
  assign rsp.cookie_end    = out_data.cookie_end;
  assign rsp.cookie_kept   = out_data.cookie_kept;
  assign rsp.cookie_slot   = out_data.cookie_slot;
  assign rsp.error_code    = out_data.error_code;
  assign rsp.report_valid  = out_data.report_valid;
  assign rsp.kept_total    = out_data.kept_total;
  assign rsp.ignored_total = out_data.ignored_total;

endmodule
